@@ design/piecewise_linear_level_profile_defines.svh @@
// assertion helpers for the top-level design file
`ifndef PIECEWISE_LINEAR_LEVEL_PROFILE_DEFINES_SVH
`define PIECEWISE_LINEAR_LEVEL_PROFILE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/plp_pkg.sv @@
package plp_pkg;

	// table depth default
	localparam int PLP_MAX_POINTS = 64;

	// field widths
	localparam int CMD_W     = 2;
	localparam int SLOT_W    = 6;
	localparam int TIME_W    = 32;
	localparam int LEVEL_W   = 32;
	localparam int COUNT_W   = 7;
	localparam int SEG_OUT_W = 6;

	// arithmetic widths
	localparam int MAG_W     = 32;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int QUO_W     = 33;
	localparam int DIV_CNT_W = $clog2(QUO_W + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD     = 2'd0,
		CMD_EVAL_ADV = 2'd1,
		CMD_EVAL     = 2'd2,
		CMD_REWIND   = 2'd3
	} cmd_t;

	// which value goes into the result word
	typedef enum logic [1:0] {
		RES_NONE,
		RES_LAST,
		RES_FLAT,
		RES_INTERP
	} res_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      capture;
		logic      mem_write;
		logic      seg_clear;
		logic      rd_en;
		logic      rd_next;
		logic      diff_en;
		logic      mul_en;
		logic      div_start;
		logic      out_load;
		logic      seg_step;
		res_kind_t res_kind;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic active;
		logic last;
		logic span_zero;
		logic advance;
		logic div_done;
	} dp_status_t;

endpackage

@@ design/plp_div.sv @@
module plp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [plp_pkg::PROD_W-1:0]   dividend,
	input  logic [plp_pkg::MAG_W-1:0]    divisor,
	output logic                         done,
	output logic                         big,
	output logic [plp_pkg::QUO_W-1:0]    quotient
);
	import plp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0]     rem_q;
	logic [MAG_W-1:0]     div_q;
	logic [QUO_W-1:0]     shf_q;
	logic                 big_q;
	logic [MAG_W:0]       trial;
	logic [MAG_W:0]       diff;
	logic                 fits;

	// one restoring step: bring down the next dividend bit and try the divisor
	assign trial = {rem_q, shf_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient shift register; high part checked for overflow up front
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= MAG_W'(dividend[PROD_W-1:QUO_W]);
			shf_q <= dividend[QUO_W-1:0];
			big_q <= MAG_W'(dividend[PROD_W-1:QUO_W]) >= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[MAG_W-1:0];
			end else begin
				rem_q <= trial[MAG_W-1:0];
			end
			shf_q <= {shf_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign big      = big_q;
	assign quotient = shf_q;

endmodule

@@ design/plp_datapath.sv @@
module plp_datapath #(
	parameter int MAX_POINTS = plp_pkg::PLP_MAX_POINTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [plp_pkg::COUNT_W-1:0]          cfg_data,
	input  logic [plp_pkg::CMD_W-1:0]            command,
	input  logic [plp_pkg::SLOT_W-1:0]           point_slot,
	input  logic [plp_pkg::TIME_W-1:0]           point_time,
	input  logic signed [plp_pkg::LEVEL_W-1:0]   point_level,
	input  logic [plp_pkg::TIME_W-1:0]           sample_time,
	input  plp_pkg::ctrl_cmd_t                   dp_cmd,
	output plp_pkg::dp_status_t                  status,
	output logic signed [plp_pkg::LEVEL_W-1:0]   level_out,
	output logic                                 level_valid,
	output logic [plp_pkg::SEG_OUT_W-1:0]        segment_now
);
	import plp_pkg::*;

	localparam int IW      = $clog2(MAX_POINTS);
	localparam int AW      = (IW > SLOT_W) ? IW : SLOT_W;
	localparam int CW      = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
	localparam int ENTRY_W = TIME_W + LEVEL_W;
	localparam int SUM_W   = QUO_W + 2;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
	localparam logic [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

	// magnitude of a difference that carries one extra sign bit
	function automatic logic [MAG_W-1:0] mag(input logic [MAG_W:0] v);
		logic [MAG_W:0] n;
		n = -v;
		mag = v[MAG_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	// captured input word
	cmd_t                 cmd_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [TIME_W-1:0]    ptime_q;
	logic [LEVEL_W-1:0]   plevel_q;
	logic [TIME_W-1:0]    t_q;

	// control state
	logic [COUNT_W-1:0]   count_q;
	logic [IW-1:0]        seg_q;

	// breakpoint memory and read path
	logic [ENTRY_W-1:0]   point_mem_q [MAX_POINTS];
	logic [ENTRY_W-1:0]   rd_q;
	logic [ENTRY_W-1:0]   e0_q;

	// segment arithmetic
	logic [MAG_W-1:0]     a_q;
	logic [MAG_W-1:0]     b_q;
	logic [MAG_W-1:0]     d_q;
	logic                 neg_q;
	logic                 span_zero_q;
	logic                 adv_q;
	logic [LEVEL_W-1:0]   y0_q;
	logic [LEVEL_W-1:0]   y1_q;
	logic [PROD_W-1:0]    prod_q;

	// result word
	logic [LEVEL_W-1:0]   level_q;
	logic                 valid_q;
	logic [SEG_OUT_W-1:0] seg_out_q;

	logic [AW:0]          slot_ext;
	logic                 slot_ok;
	logic [IW-1:0]        rd_addr;
	logic [CW-1:0]        cnt_ext;
	logic [CW-1:0]        cnt_eff;
	logic [CW-1:0]        seg_ext;
	logic [TIME_W-1:0]    x0;
	logic [TIME_W-1:0]    x1;
	logic [LEVEL_W-1:0]   y0;
	logic [LEVEL_W-1:0]   y1;
	logic [LEVEL_W:0]     dy;
	logic [TIME_W:0]      dt;
	logic [TIME_W:0]      span;
	logic                 div_done;
	logic                 div_big;
	logic [QUO_W-1:0]     quo;
	logic [SUM_W-1:0]     y0_ext;
	logic [SUM_W-1:0]     sum;
	logic [SUM_W-LEVEL_W:0] sum_top;
	logic [LEVEL_W-1:0]   interp_level;
	logic [IW-1:0]        seg_d;
	logic [LEVEL_W-1:0]   level_d;

	// input capture
	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q    <= cmd_t'(command);
			slot_q   <= point_slot;
			ptime_q  <= point_time;
			plevel_q <= point_level;
			t_q      <= sample_time;
		end
	end

	// point count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	// table occupancy against the current segment
	assign cnt_ext = CW'(count_q);
	assign cnt_eff = (cnt_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cnt_ext;
	assign seg_ext = CW'(seg_q);

	// segment index
	assign seg_d = dp_cmd.seg_step ? seg_q + IW'(1) : seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else if (dp_cmd.seg_clear) begin
			seg_q <= '0;
		end else if (dp_cmd.seg_step) begin
			seg_q <= seg_d;
		end
	end

	// breakpoint memory: one write port, one registered read port
	assign slot_ext = (AW+1)'(slot_q);
	assign slot_ok  = slot_ext < (AW+1)'(MAX_POINTS);
	assign rd_addr  = dp_cmd.rd_next ? seg_q + IW'(1) : seg_q;

	always_ff @(posedge clk) begin
		if (dp_cmd.mem_write && slot_ok) begin
			point_mem_q[slot_ext[IW-1:0]] <= {ptime_q, plevel_q};
		end
		if (dp_cmd.rd_en) begin
			rd_q <= point_mem_q[rd_addr];
		end
	end

	// hold the start point while the end point is read
	always_ff @(posedge clk) begin
		if (dp_cmd.rd_next) begin
			e0_q <= rd_q;
		end
	end

	// signed differences, split into magnitudes and one sign
	assign x0   = e0_q[ENTRY_W-1:LEVEL_W];
	assign y0   = e0_q[LEVEL_W-1:0];
	assign x1   = rd_q[ENTRY_W-1:LEVEL_W];
	assign y1   = rd_q[LEVEL_W-1:0];
	assign dy   = {y1[LEVEL_W-1], y1} - {y0[LEVEL_W-1], y0};
	assign dt   = {1'b0, t_q} - {1'b0, x0};
	assign span = {1'b0, x1} - {1'b0, x0};

	always_ff @(posedge clk) begin
		if (dp_cmd.diff_en) begin
			a_q         <= mag(dy);
			b_q         <= mag(dt);
			d_q         <= mag(span);
			neg_q       <= dy[LEVEL_W] ^ dt[TIME_W] ^ span[TIME_W];
			span_zero_q <= x1 == x0;
			adv_q       <= t_q >= x1;
			y0_q        <= y0;
			y1_q        <= y1;
		end
	end

	// magnitude product
	always_ff @(posedge clk) begin
		if (dp_cmd.mul_en) begin
			prod_q <= a_q * b_q;
		end
	end

	plp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dp_cmd.div_start),
		.dividend (prod_q),
		.divisor  (d_q),
		.done     (div_done),
		.big      (div_big),
		.quotient (quo)
	);

	// apply the signed step to the start level and saturate
	assign y0_ext  = {{(SUM_W-LEVEL_W){y0_q[LEVEL_W-1]}}, y0_q};
	assign sum     = neg_q ? y0_ext - {2'b00, quo} : y0_ext + {2'b00, quo};
	assign sum_top = sum[SUM_W-1:LEVEL_W-1];

	always_comb begin
		if (div_big) begin
			interp_level = neg_q ? LEVEL_MIN : LEVEL_MAX;
		end else if ((&sum_top) || !(|sum_top)) begin
			interp_level = sum[LEVEL_W-1:0];
		end else begin
			interp_level = sum[SUM_W-1] ? LEVEL_MIN : LEVEL_MAX;
		end
	end

	// result selection
	always_comb begin
		case (dp_cmd.res_kind)
			RES_LAST:   level_d = rd_q[LEVEL_W-1:0];
			RES_FLAT:   level_d = y1_q;
			RES_INTERP: level_d = interp_level;
			default:    level_d = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			level_q   <= level_d;
			valid_q   <= dp_cmd.res_kind != RES_NONE;
			seg_out_q <= SEG_OUT_W'(seg_d);
		end
	end

	assign status.cmd       = cmd_q;
	assign status.active    = seg_ext < cnt_eff;
	assign status.last      = (seg_ext + CW'(1)) >= cnt_eff;
	assign status.span_zero = span_zero_q;
	assign status.advance   = adv_q;
	assign status.div_done  = div_done;

	assign level_out   = level_q;
	assign level_valid = valid_q;
	assign segment_now = seg_out_q;

endmodule

@@ design/plp_ctrl.sv @@
module plp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  plp_pkg::dp_status_t  status,
	output plp_pkg::ctrl_cmd_t   dp_cmd
);
	import plp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RD0,
		ST_RD1,
		ST_DIFF,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      out_valid_q;
	logic      out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	// per-state commands
	always_comb begin
		dp_cmd          = '0;
		dp_cmd.res_kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				dp_cmd.capture = in_valid;
			end
			ST_DECODE: begin
				case (status.cmd)
					CMD_LOAD:   dp_cmd.mem_write = 1'b1;
					CMD_REWIND: dp_cmd.seg_clear = 1'b1;
					default:    ;
				endcase
			end
			ST_RD0: begin
				dp_cmd.rd_en = 1'b1;
			end
			ST_RD1: begin
				dp_cmd.rd_en   = 1'b1;
				dp_cmd.rd_next = 1'b1;
			end
			ST_DIFF: begin
				dp_cmd.diff_en = 1'b1;
			end
			ST_MUL: begin
				dp_cmd.mul_en = 1'b1;
			end
			ST_DIV_GO: begin
				dp_cmd.div_start = 1'b1;
			end
			ST_FIN: begin
				dp_cmd.out_load = out_free;
				dp_cmd.seg_step = out_free && status.cmd == CMD_EVAL_ADV && status.advance
					&& (kind_q inside {RES_INTERP, RES_FLAT});
			end
			default: ;
		endcase
	end

	// state, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (status.cmd)
						CMD_LOAD, CMD_REWIND: begin
							kind_q  <= RES_NONE;
							state_q <= ST_FIN;
						end
						default: begin
							if (status.active) begin
								state_q <= ST_RD0;
							end else begin
								kind_q  <= RES_NONE;
								state_q <= ST_FIN;
							end
						end
					endcase
				end
				ST_RD0: begin
					if (status.last) begin
						kind_q  <= RES_LAST;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (status.span_zero) begin
						kind_q  <= RES_FLAT;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (status.div_done) begin
						kind_q  <= RES_INTERP;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/piecewise_linear_level_profile.sv @@
// channel  side  handshake              word
// cfg      in    cfg_valid / cfg_ready  cfg_data (point_count)
// in       in    in_valid / in_ready    command, point_slot, point_time, point_level, sample_time
// out      out   out_valid / out_ready  level_out, level_valid, segment_now
//
// one word at a time: load, rewind and out-of-table words go straight to the result, a word on
// the last point after one read, a zero-length segment after two reads and the differences, and
// an interpolation after two reads through the single read port and the 33-step radix-2 divider.
// reset clears the segment index, point_count and control; the breakpoint memory is not cleared.
// cfg_ready is always high; the result register holds a word until out_ready, and a word
// accepted meanwhile runs up to its result and waits there.
`include "piecewise_linear_level_profile_defines.svh"

module piecewise_linear_level_profile #(
	parameter int MAX_POINTS = plp_pkg::PLP_MAX_POINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [plp_pkg::COUNT_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [plp_pkg::CMD_W-1:0]           command,
	input  logic [plp_pkg::SLOT_W-1:0]          point_slot,
	input  logic [plp_pkg::TIME_W-1:0]          point_time,
	input  logic signed [plp_pkg::LEVEL_W-1:0]  point_level,
	input  logic [plp_pkg::TIME_W-1:0]          sample_time,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [plp_pkg::LEVEL_W-1:0]  level_out,
	output logic                                level_valid,
	output logic [plp_pkg::SEG_OUT_W-1:0]       segment_now
);
	import plp_pkg::*;

	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	plp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (dp_status),
		.dp_cmd    (ctrl_cmd)
	);

	plp_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.command     (command),
		.point_slot  (point_slot),
		.point_time  (point_time),
		.point_level (point_level),
		.sample_time (sample_time),
		.dp_cmd      (ctrl_cmd),
		.status      (dp_status),
		.level_out   (level_out),
		.level_valid (level_valid),
		.segment_now (segment_now)
	);

	// checks
	`PLP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "word taken while busy")
	`PLP_ASSERT_IMPL(a_no_div_on_flat, ctrl_cmd.div_start, !dp_status.span_zero, "divide on zero span")
	`PLP_ASSERT_IMPL(a_result_reg_free, ctrl_cmd.out_load, !out_valid || out_ready, "result overwritten")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

import plp_pkg::*;

// one input word as the sender drives it
typedef struct {
	cmd_t                      command;
	logic [SLOT_W-1:0]         slot;
	logic [TIME_W-1:0]         ptime;
	logic signed [LEVEL_W-1:0] plevel;
	logic [TIME_W-1:0]         stime;
} cmd_word_t;

// one result word
typedef struct {
	logic signed [LEVEL_W-1:0] level;
	logic                      valid;
	logic [SEG_OUT_W-1:0]      seg;
} level_word_t;

// breakpoint table mirror and queue of levels still to come out
class level_scoreboard;
	logic [TIME_W-1:0]         time_tab [PLP_MAX_POINTS];
	logic signed [LEVEL_W-1:0] level_tab [PLP_MAX_POINTS];
	bit                        loaded [PLP_MAX_POINTS];
	int                        seg_idx;
	logic [COUNT_W-1:0]        count_reg;
	level_word_t               pending_levels [$];
	int                        errors;

	function void set_count(logic [COUNT_W-1:0] v);
		count_reg = v;
	endfunction

	// counts above the table depth clamp to the depth
	function int eff_count();
		return (count_reg > PLP_MAX_POINTS) ? PLP_MAX_POINTS : int'(count_reg);
	endfunction

	// lowest readable entry not yet loaded, -1 if none
	function int first_hole();
		for (int i = 0; i < eff_count(); i++)
			if (!loaded[i])
				return i;
		return -1;
	endfunction

	function int pending();
		return pending_levels.size();
	endfunction

	function logic [63:0] magnitude(longint v, inout bit neg);
		if (v < 0) begin
			neg = !neg;
			return 64'(-v);
		end
		return 64'(v);
	endfunction

	// y0 + dy*dt/span, quotient truncated and clamped to 2^40, then saturated
	function logic signed [LEVEL_W-1:0] interp_level(int k, logic [TIME_W-1:0] t);
		longint      y0, x0, x1, span, dy, dt, sum;
		logic [63:0] mag_dy, mag_dt, mag_span;
		logic [127:0] quo;
		bit          neg;
		y0 = longint'(level_tab[k]);
		x0 = longint'({32'h0, time_tab[k]});
		x1 = longint'({32'h0, time_tab[k+1]});
		span = x1 - x0;
		// zero-length segment gives its end level
		if (span == 0)
			return level_tab[k+1];
		neg = 1'b0;
		dy = longint'(level_tab[k+1]) - y0;
		dt = longint'({32'h0, t}) - x0;
		mag_dy = magnitude(dy, neg);
		mag_dt = magnitude(dt, neg);
		mag_span = magnitude(span, neg);
		quo = 128'(mag_dy) * 128'(mag_dt);
		quo = quo / 128'(mag_span);
		if (quo > (128'd1 << 40))
			quo = 128'd1 << 40;
		sum = neg ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
		if (sum > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (sum < -64'sd2147483648)
			return 32'sh8000_0000;
		return sum[31:0];
	endfunction

	// accepted input word: update the mirror and queue its result
	function void note_word(cmd_word_t w);
		level_word_t want;
		int          cnt;
		cnt = eff_count();
		want.level = '0;
		want.valid = 1'b0;
		case (w.command)
			CMD_LOAD: begin
				time_tab[w.slot] = w.ptime;
				level_tab[w.slot] = w.plevel;
				loaded[w.slot] = 1'b1;
			end
			CMD_REWIND: seg_idx = 0;
			default: begin
				// no valid level comes out once the index is past the table
				if (seg_idx < cnt) begin
					want.valid = 1'b1;
					if (seg_idx + 1 >= cnt) begin
						want.level = level_tab[seg_idx];
					end else begin
						want.level = interp_level(seg_idx, w.stime);
						if (w.command == CMD_EVAL_ADV && w.stime >= time_tab[seg_idx+1])
							seg_idx++;
					end
				end
			end
		endcase
		want.seg = seg_idx[SEG_OUT_W-1:0];
		pending_levels.insert(pending_levels.size(), want);
	endfunction

	// accepted result word against the oldest queued level
	function void check_result(level_word_t got);
		level_word_t want;
		if (pending_levels.size() == 0) begin
			$display("%0t: result with nothing queued: level %h valid %b segment %0d",
				$time, got.level, got.valid, got.seg);
			errors++;
			return;
		end
		want = pending_levels.pop_front();
		if (got.level !== want.level) begin
			$display("%0t: level_out expected %h actual %h", $time, want.level, got.level);
			errors++;
		end
		if (got.valid !== want.valid) begin
			$display("%0t: level_valid expected %b actual %b", $time, want.valid, got.valid);
			errors++;
		end
		if (got.seg !== want.seg) begin
			$display("%0t: segment_now expected %0d actual %0d", $time, want.seg, got.seg);
			errors++;
		end
	endfunction
endclass

module tb_top;

	localparam int SETTLE_CYCLES = 50;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [COUNT_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [CMD_W-1:0]          command;
	logic [SLOT_W-1:0]         point_slot;
	logic [TIME_W-1:0]         point_time;
	logic signed [LEVEL_W-1:0] point_level;
	logic [TIME_W-1:0]         sample_time;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [LEVEL_W-1:0] level_out;
	logic                      level_valid;
	logic [SEG_OUT_W-1:0]      segment_now;

	level_scoreboard sb;
	int              send_idle_pct;
	int              recv_stall_pct;
	int unsigned     table_step;

	piecewise_linear_level_profile i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.point_slot  (point_slot),
		.point_time  (point_time),
		.point_level (point_level),
		.sample_time (sample_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.level_out   (level_out),
		.level_valid (level_valid),
		.segment_now (segment_now)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result words
	always @(posedge clk) begin : result_monitor
		level_word_t got;
		if (arst_n === 1'b1 && out_valid && out_ready) begin
			got.level = level_out;
			got.valid = level_valid;
			got.seg = segment_now;
			sb.check_result(got);
		end
	end

	// run limit
	initial begin
		#15_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic cmd_word_t make_word(cmd_t c, logic [SLOT_W-1:0] s,
			logic [TIME_W-1:0] pt, logic [LEVEL_W-1:0] pl, logic [TIME_W-1:0] st);
		cmd_word_t w;
		w.command = c;
		w.slot = s;
		w.ptime = pt;
		w.plevel = pl;
		w.stime = st;
		return w;
	endfunction

	// random word, mostly ramp tables and sweeps along the current segment
	function automatic cmd_word_t pick_word();
		cmd_word_t        w;
		int               cnt, hole, r, seg;
		logic [TIME_W-1:0] x0, x1;
		w.command = CMD_EVAL_ADV;
		w.slot = SLOT_W'($urandom);
		w.ptime = $urandom;
		w.plevel = $urandom;
		w.stime = $urandom;
		cnt = sb.eff_count();
		hole = sb.first_hole();
		r = $urandom_range(99);
		// every readable entry gets loaded before any evaluation
		if (hole >= 0) begin
			r = 0;
			w.slot = SLOT_W'(hole);
		end
		if (r < 12) begin
			w.command = CMD_LOAD;
			if (hole >= 0 || $urandom_range(3) != 0) begin
				if (hole < 0 && cnt < PLP_MAX_POINTS)
					w.slot = SLOT_W'($urandom_range(cnt));
				w.ptime = w.slot * table_step + $urandom_range(table_step / 4);
				if ($urandom_range(1))
					w.plevel = $urandom_range(32'h00C8_0000) - 32'h0064_0000;
			end
		end else if (r < 14) begin
			w.command = CMD_REWIND;
		end else begin
			w.command = (r < 35) ? CMD_EVAL : CMD_EVAL_ADV;
			seg = sb.seg_idx;
			// aim at the breakpoints of the current segment
			if (seg + 1 < cnt) begin
				x0 = sb.time_tab[seg];
				x1 = sb.time_tab[seg+1];
				case ($urandom_range(9))
					0, 1, 2: w.stime = x1;
					3: w.stime = x1 - 1;
					4, 5: w.stime = (x1 > x0) ? x0 + $urandom_range(x1 - x0) : x0;
					6: w.stime = '0;
					7: w.stime = '1;
					default: ;
				endcase
			end
		end
		return w;
	endfunction

	task automatic send_word(input cmd_word_t w);
		int gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < send_idle_pct)
			gap++;
		// sender idle ahead of the word
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= w.command;
		point_slot <= w.slot;
		point_time <= w.ptime;
		point_level <= w.plevel;
		sample_time <= w.stime;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		@(negedge clk);
	endtask

	// stop sending until every queued level is out
	task automatic hold_until_empty();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] v);
		hold_until_empty();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_count(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] count_val, input int n_words,
			input int send_pct, input int recv_pct, input int unsigned step_val);
		write_count(count_val);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		table_step = step_val;
		for (int i = 0; i < n_words; i++) begin
			// let the block run dry now and then
			if (i == n_words / 2 || $urandom_range(79) == 0)
				hold_until_empty();
			send_word(pick_word());
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_LOAD;
		point_slot = '0;
		point_time = '0;
		point_level = '0;
		sample_time = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		table_step = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, then a small table with a flat and a falling segment
		write_count(7'd0);
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, '0));
		send_word(make_word(CMD_EVAL, 6'd0, '0, '0, '1));
		send_word(make_word(CMD_REWIND, 6'd63, '1, '1, '1));
		send_word(make_word(CMD_LOAD, 6'd0, 32'd0, 32'h7FFF_FFFF, '0));
		send_word(make_word(CMD_LOAD, 6'd1, 32'd100, 32'h8000_0000, '0));
		send_word(make_word(CMD_LOAD, 6'd2, 32'd100, 32'h0001_8000, '0));
		send_word(make_word(CMD_LOAD, 6'd3, 32'd50, 32'h0001_0000, '0));
		send_word(make_word(CMD_LOAD, 6'd4, '1, 32'hFFFF_0000, '0));
		send_word(make_word(CMD_LOAD, 6'd63, '1, 32'h0, '1));

		write_count(7'd5);
		send_word(make_word(CMD_EVAL, 6'd0, '0, '0, 32'd0));
		send_word(make_word(CMD_EVAL, 6'd0, '0, '0, 32'd50));
		// extrapolation far past the segment saturates
		send_word(make_word(CMD_EVAL, 6'd0, '0, '0, '1));
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, 32'd99));
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, 32'd100));
		send_word(make_word(CMD_EVAL, 6'd0, '0, '0, 32'd0));
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, 32'd100));
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, 32'd0));
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, '1));
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, '1));
		// on the last point the index stays put
		send_word(make_word(CMD_EVAL_ADV, 6'd0, '0, '0, 32'd7));
		send_word(make_word(CMD_EVAL, 6'd0, '0, '0, 32'd0));
		send_word(make_word(CMD_REWIND, 6'd0, '0, '0, '0));
		send_word(make_word(CMD_EVAL, 6'd0, '0, '0, 32'd25));

		// random phases across counts and idling patterns
		run_phase(7'd64, 250, 0, 0, 32'h0100_0000);
		run_phase(7'd127, 200, 78, 0, 1000);
		run_phase(7'd1, 100, 0, 78, 16);
		run_phase(7'd3, 200, 17, 17, 32'h0400_0000);
		run_phase(7'($urandom_range(2, 16)), 200, 0, 0, 0);
		run_phase(7'd65, 150, 17, 17, 32'h0000_8000);
		run_phase(7'($urandom_range(0, 127)), 100, 0, 0, $urandom);

		hold_until_empty();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ piecewise_linear_level_profile.f @@
+incdir+design
design/plp_pkg.sv
design/plp_div.sv
design/plp_datapath.sv
design/plp_ctrl.sv
design/piecewise_linear_level_profile.sv
test/tb_top.sv
